>>> design/sfcm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfcm_pkg
// Shared widths, item types and codes of the segment free and compact manager.
// ----------------------------------------------------------------------------
package sfcm_pkg;

	localparam int SEG_ENTRIES  = 64;
	localparam int HOLE_ENTRIES = 64;
	localparam int ADDR_BITS    = 20;
	localparam int SIZE_BITS    = ADDR_BITS + 1;
	localparam int END_BITS     = ADDR_BITS + 2;
	localparam int SEG_IDX_W    = $clog2(SEG_ENTRIES);
	localparam int SEG_CW       = SEG_IDX_W + 1;
	localparam int HOLE_IDX_W   = $clog2(HOLE_ENTRIES);
	localparam int HOLE_CNT_W   = $clog2(HOLE_ENTRIES + 2);
	localparam int USED_BITS    = SIZE_BITS + $clog2(SEG_ENTRIES + 1);

	localparam logic [1:0] CMD_LOAD_SEG  = 2'd0;
	localparam logic [1:0] CMD_LOAD_HOLE = 2'd1;
	localparam logic [1:0] CMD_DELETE    = 2'd2;
	localparam logic [1:0] CMD_COMPACT   = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;

	typedef struct packed {
		logic [1:0]           cmd;
		logic [7:0]           process_id;
		logic [7:0]           segment_id;
		logic [ADDR_BITS-1:0] base_in;
		logic [SIZE_BITS-1:0] length_in;
	} in_item_t;

	typedef struct packed {
		logic [1:0]            status;
		logic [ADDR_BITS-1:0]  result_base;
		logic [SIZE_BITS-1:0]  result_size;
		logic [SIZE_BITS-1:0]  remaining_memory;
		logic [HOLE_CNT_W-1:0] hole_count;
	} out_item_t;

	typedef struct packed {
		logic [7:0]           process_id;
		logic [7:0]           segment_id;
		logic [ADDR_BITS-1:0] base;
		logic [SIZE_BITS-1:0] size;
	} seg_entry_t;

	typedef struct packed {
		logic [ADDR_BITS-1:0] base;
		logic [SIZE_BITS-1:0] size;
	} hole_entry_t;

endpackage
`default_nettype wire

>>> design/segment_free_and_compact_manager_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// segment_free_and_compact_manager_unit
// Segment table and sorted free-hole table with coalescing and compaction.
// ----------------------------------------------------------------------------
// One item at a time; a result waits in an output register while the next item
// is taken. Segment load runs a full sweep of the segment RAM, one entry a cycle.
// Hole load makes one read and one merge step per hole. Delete takes the segment
// sweep plus the hole pass, and twice the hole pass when the hole table is full
// (a dry pass checks the fit first). In compaction, each placed segment costs one
// sweep of the segment RAM to pick the next lowest base.
// Segment valid bits are flip-flops cleared by reset; no clearing pass is run.
// ----------------------------------------------------------------------------
module segment_free_and_compact_manager_unit (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [sfcm_pkg::SIZE_BITS-1:0] cfg_wdata,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire sfcm_pkg::in_item_t     in_data,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output sfcm_pkg::out_item_t         out_data
);

	localparam int AB = sfcm_pkg::ADDR_BITS;
	localparam int SB = sfcm_pkg::SIZE_BITS;
	localparam int EB = sfcm_pkg::END_BITS;
	localparam int SIW = sfcm_pkg::SEG_IDX_W;
	localparam int SCW = sfcm_pkg::SEG_CW;
	localparam int HIW = sfcm_pkg::HOLE_IDX_W;
	localparam int HCW = sfcm_pkg::HOLE_CNT_W;
	localparam int UB = sfcm_pkg::USED_BITS;
	localparam int NSEG = sfcm_pkg::SEG_ENTRIES;
	localparam logic [EB-1:0] ADDR_MAX = EB'((64'd1 << AB) - 64'd1);
	localparam logic [EB-1:0] SIZE_MAX = EB'((64'd1 << SB) - 64'd1);

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN, S_LOAD_WR, S_H_RD, S_H_PROC, S_H_END,
		S_C_HRD, S_C_SCAN, S_C_PLACE, S_C_END, S_FIN
	} state_t;

	function automatic logic counted(input logic [7:0] pid, input logic [7:0] sid);
		counted = ((pid == 8'd0) && (sid == 8'd0)) || ((pid != 8'd0) && (sid != 8'd0));
	endfunction

	state_t                 state_q;
	sfcm_pkg::in_item_t     item_q;
	logic [SCW-1:0]         scan_q;
	logic                   pend_s1;
	logic [SIW-1:0]         idx_s1;
	logic                   found_v_q;
	logic [SIW-1:0]         found_idx_q;
	sfcm_pkg::seg_entry_t   found_q;
	logic                   free_v_q;
	logic [SIW-1:0]         free_idx_q;
	logic [NSEG-1:0]        valid_q;
	logic [NSEG-1:0]        placed_q;
	logic [HCW-1:0]         holes_q;
	logic [UB-1:0]          used_q;
	logic [SB-1:0]          mem_size_q;
	logic [1:0]             status_q;
	logic [AB-1:0]          rbase_q;
	logic [SB-1:0]          rsize_q;
	logic [HCW-1:0]         hr_q;
	logic [HCW-1:0]         hk_q;
	logic                   ins_done_q;
	logic                   acc_v_q;
	sfcm_pkg::hole_entry_t  acc_q;
	sfcm_pkg::hole_entry_t  nh_q;
	logic                   merge_en_q;
	logic                   dry_q;
	logic                   best_v_q;
	logic [SIW-1:0]         best_idx_q;
	sfcm_pkg::seg_entry_t   best_q;
	logic [EB-1:0]          packed_q;
	logic                   last_v_q;
	logic [AB-1:0]          last_base_q;
	logic [SB-1:0]          last_size_q;
	logic                   out_valid_q;
	sfcm_pkg::out_item_t    out_q;

	logic                   seg_we;
	logic [SIW-1:0]         seg_waddr;
	sfcm_pkg::seg_entry_t   seg_wdata;
	logic                   seg_re;
	sfcm_pkg::seg_entry_t   seg_rdata;
	logic                   hole_we;
	logic [HIW-1:0]         hole_waddr;
	sfcm_pkg::hole_entry_t  hole_wdata;
	logic                   hole_re;
	logic [HIW-1:0]         hole_raddr;
	sfcm_pkg::hole_entry_t  hole_rdata;

	// hole stream
	logic                   take_new;
	logic                   at_end;
	sfcm_pkg::hole_entry_t  elem;
	logic                   touch;
	logic [EB-1:0]          msum;
	logic [SB-1:0]          msize;
	logic                   emit;

	// slot and sums
	logic [SIW-1:0]         slot;
	logic [AB-1:0]          new_base;
	logic [EB-1:0]          hole_end;
	logic [EB-1:0]          old_end;
	logic [EB-1:0]          diff;
	logic [AB-1:0]          c_rbase;
	logic [SB-1:0]          c_rsize;
	logic [SB-1:0]          remaining;
	logic                   scan_more;

	sfcm_ram #(.DEPTH(NSEG), .WIDTH($bits(sfcm_pkg::seg_entry_t))) u_seg_ram (
		.clk(clk), .we(seg_we), .waddr(seg_waddr), .wdata(seg_wdata),
		.re(seg_re), .raddr(scan_q[SIW-1:0]), .rdata(seg_rdata)
	);

	sfcm_ram #(.DEPTH(sfcm_pkg::HOLE_ENTRIES),
		.WIDTH($bits(sfcm_pkg::hole_entry_t))) u_hole_ram (
		.clk(clk), .we(hole_we), .waddr(hole_waddr), .wdata(hole_wdata),
		.re(hole_re), .raddr(hole_raddr), .rdata(hole_rdata)
	);

	assign scan_more = scan_q < SCW'(NSEG);
	assign slot = found_v_q ? found_idx_q : free_idx_q;
	assign new_base = (packed_q > ADDR_MAX) ? ADDR_MAX[AB-1:0] : packed_q[AB-1:0];

	always_comb begin
		take_new = !ins_done_q && ((hr_q == holes_q) || (hole_rdata.base > nh_q.base));
		at_end = ins_done_q && (hr_q == holes_q);
		elem = take_new ? nh_q : hole_rdata;
		msum = EB'(acc_q.base) + EB'(acc_q.size);
		touch = merge_en_q && (msum == EB'(elem.base));
		msize = ((EB'(acc_q.size) + EB'(elem.size)) > SIZE_MAX) ? SIZE_MAX[SB-1:0]
			: SB'(EB'(acc_q.size) + EB'(elem.size));
		emit = (state_q == S_H_PROC) && (at_end || (acc_v_q && !touch));
	end

	always_comb begin
		hole_end = EB'(hole_rdata.base) + EB'(hole_rdata.size);
		if (last_v_q) begin
			if ((holes_q != '0) && !(last_base_q > hole_rdata.base)) begin
				old_end = hole_end;
			end else begin
				old_end = EB'(last_base_q) + EB'(last_size_q);
			end
		end else if (holes_q != '0) begin
			old_end = hole_end;
		end else begin
			old_end = '0;
		end
		diff = (old_end > packed_q) ? (old_end - packed_q) : '0;
		c_rsize = (diff > SIZE_MAX) ? SIZE_MAX[SB-1:0] : diff[SB-1:0];
		c_rbase = new_base;
		remaining = (used_q >= UB'(mem_size_q)) ? '0 : SB'(UB'(mem_size_q) - used_q);
	end

	always_comb begin
		seg_re = ((state_q == S_SCAN) || (state_q == S_C_SCAN)) && scan_more;
		seg_we = 1'b0;
		seg_waddr = slot;
		seg_wdata = '{item_q.process_id, item_q.segment_id, item_q.base_in,
			item_q.length_in};
		if ((state_q == S_LOAD_WR) && (found_v_q || free_v_q)) begin
			seg_we = 1'b1;
		end else if (state_q == S_C_PLACE) begin
			seg_we = 1'b1;
			seg_waddr = best_idx_q;
			seg_wdata = '{best_q.process_id, best_q.segment_id, new_base, best_q.size};
		end
		hole_re = 1'b0;
		hole_raddr = hr_q[HIW-1:0];
		if ((state_q == S_H_RD) && (hr_q < holes_q)) begin
			hole_re = 1'b1;
		end else if ((state_q == S_C_HRD) && (holes_q != '0)) begin
			hole_re = 1'b1;
			hole_raddr = HIW'(holes_q - 1'b1);
		end
		hole_we = 1'b0;
		hole_waddr = hk_q[HIW-1:0];
		hole_wdata = acc_q;
		if (emit && !dry_q) begin
			hole_we = 1'b1;
		end else if (state_q == S_C_END) begin
			hole_we = 1'b1;
			hole_waddr = '0;
			hole_wdata = '{c_rbase, c_rsize};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			placed_q <= '0;
			holes_q <= '0;
			used_q <= '0;
			mem_size_q <= SB'(1 << AB);
			out_valid_q <= 1'b0;
			pend_s1 <= 1'b0;
			found_v_q <= 1'b0;
			free_v_q <= 1'b0;
			best_v_q <= 1'b0;
			last_v_q <= 1'b0;
			acc_v_q <= 1'b0;
			ins_done_q <= 1'b0;
			dry_q <= 1'b0;
			merge_en_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				mem_size_q <= cfg_wdata;
			end
			if (out_valid_q && out_ready && (state_q != S_FIN)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						item_q <= in_data;
						status_q <= sfcm_pkg::ST_OK;
						rbase_q <= '0;
						rsize_q <= '0;
						scan_q <= '0;
						pend_s1 <= 1'b0;
						found_v_q <= 1'b0;
						free_v_q <= 1'b0;
						best_v_q <= 1'b0;
						last_v_q <= 1'b0;
						packed_q <= '0;
						placed_q <= '0;
						hr_q <= '0;
						hk_q <= '0;
						ins_done_q <= 1'b0;
						acc_v_q <= 1'b0;
						nh_q <= '{in_data.base_in, in_data.length_in};
						merge_en_q <= 1'b0;
						dry_q <= 1'b0;
						case (in_data.cmd)
							sfcm_pkg::CMD_LOAD_HOLE: begin
								if (holes_q >= HCW'(sfcm_pkg::HOLE_ENTRIES)) begin
									status_q <= sfcm_pkg::ST_FULL;
									state_q <= S_FIN;
								end else begin
									state_q <= S_H_RD;
								end
							end
							sfcm_pkg::CMD_COMPACT: state_q <= S_C_HRD;
							default: state_q <= S_SCAN;
						endcase
					end
				end
				S_SCAN, S_C_SCAN: begin
					if (scan_more) begin
						scan_q <= scan_q + 1'b1;
						idx_s1 <= scan_q[SIW-1:0];
						pend_s1 <= 1'b1;
					end else begin
						pend_s1 <= 1'b0;
					end
					if (pend_s1 && (state_q == S_SCAN)) begin
						if (valid_q[idx_s1]) begin
							if (!found_v_q && (seg_rdata.process_id == item_q.process_id)
								&& (seg_rdata.segment_id == item_q.segment_id)) begin
								found_v_q <= 1'b1;
								found_idx_q <= idx_s1;
								found_q <= seg_rdata;
							end
						end else if (!free_v_q) begin
							free_v_q <= 1'b1;
							free_idx_q <= idx_s1;
						end
					end
					if (pend_s1 && (state_q == S_C_SCAN) && valid_q[idx_s1]
						&& !placed_q[idx_s1]
						&& counted(seg_rdata.process_id, seg_rdata.segment_id)
						&& (!best_v_q || (seg_rdata.base < best_q.base))) begin
						best_v_q <= 1'b1;
						best_idx_q <= idx_s1;
						best_q <= seg_rdata;
					end
					if (!scan_more && !pend_s1) begin
						if (state_q == S_C_SCAN) begin
							state_q <= best_v_q ? S_C_PLACE : S_C_END;
						end else if (item_q.cmd == sfcm_pkg::CMD_LOAD_SEG) begin
							state_q <= S_LOAD_WR;
						end else if (!found_v_q) begin
							status_q <= sfcm_pkg::ST_NOT_FOUND;
							state_q <= S_FIN;
						end else begin
							nh_q <= '{found_q.base, found_q.size};
							merge_en_q <= 1'b1;
							dry_q <= (holes_q == HCW'(sfcm_pkg::HOLE_ENTRIES));
							state_q <= S_H_RD;
						end
					end
				end
				S_LOAD_WR: begin
					if (found_v_q || free_v_q) begin
						valid_q[slot] <= 1'b1;
						used_q <= used_q
							- ((found_v_q && counted(found_q.process_id, found_q.segment_id))
								? UB'(found_q.size) : UB'(0))
							+ (counted(item_q.process_id, item_q.segment_id)
								? UB'(item_q.length_in) : UB'(0));
					end else begin
						status_q <= sfcm_pkg::ST_FULL;
					end
					state_q <= S_FIN;
				end
				S_H_RD: state_q <= S_H_PROC;
				S_H_PROC: begin
					if (at_end) begin
						hk_q <= hk_q + 1'b1;
						state_q <= S_H_END;
					end else begin
						if (!acc_v_q) begin
							acc_q <= elem;
							acc_v_q <= 1'b1;
						end else if (touch) begin
							acc_q.size <= msize;
						end else begin
							hk_q <= hk_q + 1'b1;
							acc_q <= elem;
						end
						if (take_new) begin
							ins_done_q <= 1'b1;
						end else begin
							hr_q <= hr_q + 1'b1;
							state_q <= S_H_RD;
						end
					end
				end
				S_H_END: begin
					hr_q <= '0;
					hk_q <= '0;
					ins_done_q <= 1'b0;
					acc_v_q <= 1'b0;
					if (dry_q) begin
						dry_q <= 1'b0;
						if (hk_q > HCW'(sfcm_pkg::HOLE_ENTRIES)) begin
							status_q <= sfcm_pkg::ST_FULL;
							state_q <= S_FIN;
						end else begin
							state_q <= S_H_RD;
						end
					end else begin
						holes_q <= hk_q;
						if (item_q.cmd == sfcm_pkg::CMD_DELETE) begin
							valid_q[found_idx_q] <= 1'b0;
							if (counted(found_q.process_id, found_q.segment_id)) begin
								used_q <= used_q - UB'(found_q.size);
							end
							rbase_q <= found_q.base;
							rsize_q <= found_q.size;
						end
						state_q <= S_FIN;
					end
				end
				S_C_HRD: state_q <= S_C_SCAN;
				S_C_PLACE: begin
					placed_q[best_idx_q] <= 1'b1;
					packed_q <= EB'(new_base) + EB'(best_q.size);
					last_v_q <= 1'b1;
					last_base_q <= best_q.base;
					last_size_q <= best_q.size;
					best_v_q <= 1'b0;
					scan_q <= '0;
					state_q <= S_C_SCAN;
				end
				S_C_END: begin
					rbase_q <= c_rbase;
					rsize_q <= c_rsize;
					holes_q <= HCW'(1);
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_q <= '{status_q, rbase_q, rsize_q, remaining, holes_q};
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule
`default_nettype wire

>>> design/sfcm_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfcm_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sfcm_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 8,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

>>> design/sfcm_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfcm_checker
// Port-level checks of the segment free and compact manager.
// ----------------------------------------------------------------------------
module sfcm_checker (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   in_valid,
	input wire logic                   in_ready,
	input wire logic                   out_valid,
	input wire logic                   out_ready,
	input wire sfcm_pkg::out_item_t    out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result item changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready right after an accepted item");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.status == sfcm_pkg::ST_OK)
			|| (out_data.status == sfcm_pkg::ST_NOT_FOUND)
			|| (out_data.status == sfcm_pkg::ST_FULL))
		else $error("bad status code");

	a_hole_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.hole_count
			<= sfcm_pkg::HOLE_CNT_W'(sfcm_pkg::HOLE_ENTRIES))
		else $error("hole count above table depth");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status != sfcm_pkg::ST_OK)
			|-> (out_data.result_base == '0) && (out_data.result_size == '0))
		else $error("failed item reports a range");

endmodule

bind segment_free_and_compact_manager_unit sfcm_checker u_sfcm_checker (.*);
`default_nettype wire
